FILE: hdl/msps_pkg.sv
// Package for the maze shortest-path search block.
// Types, grid constants and an edge-index helper function; no dependencies.
package msps_pkg;

  localparam int MAZE_W    = 4;
  localparam int MAZE_H    = 5;
  localparam int NUM_CELLS = MAZE_W * MAZE_H;
  localparam int EDGE_COLS = 2 * MAZE_W + 1;
  localparam int EDGE_ROWS = 2 * MAZE_H + 1;
  localparam int NUM_EDGES = EDGE_ROWS * EDGE_COLS;
  localparam int CW        = $clog2(NUM_CELLS);
  localparam int EW        = $clog2(NUM_EDGES);
  localparam int XW        = 2;
  localparam int YW        = 3;
  localparam int SW        = 5;

  localparam logic [0:0] FUNC_EDGE  = 1'b0;
  localparam logic [0:0] FUNC_SOLVE = 1'b1;

  localparam logic [1:0] SIDE_N = 2'd0;
  localparam logic [1:0] SIDE_E = 2'd1;
  localparam logic [1:0] SIDE_S = 2'd2;
  localparam logic [1:0] SIDE_W = 2'd3;

  localparam logic [0:0] REG_TARGET_X = 1'b0;
  localparam logic [0:0] REG_TARGET_Y = 1'b1;

  typedef struct packed {
    logic [0:0]    func;
    logic [XW-1:0] cell_x;
    logic [YW-1:0] cell_y;
    logic [1:0]    side;
    logic          open;
  } in_item_t;

  typedef struct packed {
    logic [XW-1:0] path_x;
    logic [YW-1:0] path_y;
    logic [SW-1:0] step;
    logic [1:0]    turn;
    logic          found;
    logic          last;
  } out_item_t;

  // Classified command from front to back
  typedef struct packed {
    logic          is_solve;
    logic [EW-1:0] eidx;
    logic          open;
  } cmd_t;

  function automatic logic [EW-1:0] edge_index(input logic [XW-1:0] x,
                                               input logic [YW-1:0] y,
                                               input logic [1:0] side);
    logic [EW-1:0] r;
    logic [EW-1:0] c;
    r = EW'(2 * int'(y) + 1);
    c = EW'(2 * int'(x) + 1);
    case (side)
      SIDE_N:  r = r + 1'b1;
      SIDE_E:  c = c + 1'b1;
      SIDE_S:  r = r - 1'b1;
      default: c = c - 1'b1;
    endcase
    return EW'(int'(r) * EDGE_COLS + int'(c));
  endfunction

endpackage

FILE: hdl/msps_if.sv
// Valid/ready channel interface for the maze search block.
// Depends on nothing; payload type is a parameter.
interface msps_if #(parameter type T = logic) ();
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

FILE: hdl/msps_cfg_if.sv
// Configuration write channel: register index and data.
// Depends on nothing.
interface msps_cfg_if ();
  logic       valid;
  logic       ready;
  logic [0:0] index;
  logic [7:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: hdl/msps_front.sv
// Front end: accepts items, classifies them, feeds a 2-entry command queue.
// Depends on msps_pkg.
module msps_front import msps_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  in_item_t in_data,
  output logic     cmd_valid,
  input  logic     cmd_ready,
  output cmd_t     cmd_data
);
  cmd_t       q_r [2];
  logic [1:0] cnt_r, cnt_nxt;
  logic       rd_r, wr_r;
  logic       push, pop, inside_grid;
  cmd_t       cmd;

  assign inside_grid = (int'(in_data.cell_x) < MAZE_W) && (int'(in_data.cell_y) < MAZE_H);
  assign cmd.is_solve = (in_data.func == FUNC_SOLVE);
  assign cmd.eidx     = edge_index(in_data.cell_x, in_data.cell_y, in_data.side);
  assign cmd.open     = in_data.open;

  assign in_ready  = (cnt_r != 2'd2);
  // Out-of-grid edge writes are dropped here
  assign push      = in_valid && in_ready && (cmd.is_solve || inside_grid);
  assign cmd_valid = (cnt_r != 2'd0);
  assign pop       = cmd_valid && cmd_ready;
  assign cmd_data  = q_r[rd_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) cnt_nxt = cnt_r + 2'd1;
    else if (pop && !push) cnt_nxt = cnt_r - 2'd1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      rd_r  <= 1'b0;
      wr_r  <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) wr_r <= ~wr_r;
      if (pop) rd_r <= ~rd_r;
    end
    if (push) q_r[wr_r] <= cmd;
  end
endmodule

FILE: hdl/msps_back.sv
// Back end: edge map, breadth-first search, backtrack and path emission.
// Depends on msps_pkg.
module msps_back import msps_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          cmd_valid,
  output logic          cmd_ready,
  input  cmd_t          cmd_data,
  input  logic [XW-1:0] tgt_x,
  input  logic [YW-1:0] tgt_y,
  output logic          out_valid,
  input  logic          out_ready,
  output out_item_t     out_data
);
  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_POP  = 3'd1;
  localparam logic [2:0] ST_NBR  = 3'd2;
  localparam logic [2:0] ST_BACK = 3'd3;
  localparam logic [2:0] ST_EMIT = 3'd4;
  localparam logic [2:0] ST_FAIL = 3'd5;
  localparam logic [2:0] ST_CLR  = 3'd6;

  logic [2:0]          st_r;
  logic                edge_mem [NUM_EDGES];
  logic                edge_rd_r;
  logic [EW-1:0]       clr_r;
  logic [NUM_CELLS-1:0] seen_r;
  logic [CW-1:0]       parent_r [NUM_CELLS];
  logic [SW-1:0]       dist_r   [NUM_CELLS];
  logic [CW-1:0]       queue_r  [NUM_CELLS];
  logic [CW-1:0]       stack_r  [NUM_CELLS];
  logic [CW:0]         head_r, tail_r;
  logic [CW-1:0]       cur_r;
  logic [1:0]          s_r;
  logic [SW-1:0]       i_r, len_r;
  logic [1:0]          heading_r;
  logic [XW-1:0]       px_r;
  logic [YW-1:0]       py_r;
  logic                ovalid_r;
  out_item_t           odata_r;

  logic [XW-1:0] cx, ex, qx;
  logic [YW-1:0] cy, ey, qy;
  logic [CW-1:0] target, nbr, ec, qc;
  logic          nbr_ok, tgt_ok, slot, emit_go;
  logic [1:0]    move;
  logic [EW-1:0] rd_addr, mem_wa;
  logic          mem_we, mem_wd;

  assign cx = XW'(int'(cur_r) % MAZE_W);
  assign cy = YW'(int'(cur_r) / MAZE_W);
  assign tgt_ok = (int'(tgt_x) < MAZE_W) && (int'(tgt_y) < MAZE_H);
  assign target = CW'(int'(tgt_y) * MAZE_W + int'(tgt_x));

  // Queue head, and the edge to fetch for the next neighbor check
  assign qc = queue_r[head_r[CW-1:0]];
  assign qx = XW'(int'(qc) % MAZE_W);
  assign qy = YW'(int'(qc) / MAZE_W);
  assign rd_addr = (st_r == ST_POP) ? edge_index(qx, qy, SIDE_N)
                                    : edge_index(cx, cy, s_r + 2'd1);

  // Edge memory: one write port (clear pass or edge command), registered read
  always_comb begin
    mem_we = 1'b0;
    mem_wa = clr_r;
    mem_wd = 1'b0;
    if (st_r == ST_CLR) begin
      mem_we = 1'b1;
    end else if (st_r == ST_IDLE && cmd_valid && !cmd_data.is_solve) begin
      mem_we = 1'b1;
      mem_wa = cmd_data.eidx;
      mem_wd = cmd_data.open;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) edge_mem[mem_wa] <= mem_wd;
    edge_rd_r <= edge_mem[rd_addr];
  end

  always_comb begin
    nbr_ok = edge_rd_r;
    nbr    = cur_r;
    case (s_r)
      SIDE_N: begin
        nbr_ok = nbr_ok && (int'(cy) + 1 < MAZE_H);
        nbr = CW'(int'(cur_r) + MAZE_W);
      end
      SIDE_E: begin
        nbr_ok = nbr_ok && (int'(cx) + 1 < MAZE_W);
        nbr = cur_r + 1'b1;
      end
      SIDE_S: begin
        nbr_ok = nbr_ok && (cy != '0);
        nbr = CW'(int'(cur_r) - MAZE_W);
      end
      default: begin
        nbr_ok = nbr_ok && (cx != '0);
        nbr = cur_r - 1'b1;
      end
    endcase
  end

  // Emission cell and heading
  assign ec = stack_r[i_r];
  assign ex = XW'(int'(ec) % MAZE_W);
  assign ey = YW'(int'(ec) / MAZE_W);
  always_comb begin
    move = heading_r;
    if (ey > py_r) move = SIDE_N;
    else if (ex > px_r) move = SIDE_E;
    else if (ey < py_r) move = SIDE_S;
    else if (ex < px_r) move = SIDE_W;
  end

  assign slot      = !ovalid_r || out_ready;
  assign emit_go   = slot && ((st_r == ST_EMIT) || (st_r == ST_FAIL));
  assign cmd_ready = (st_r == ST_IDLE);
  assign out_valid = ovalid_r;
  assign out_data  = odata_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r     <= ST_CLR;
      clr_r    <= '0;
      ovalid_r <= 1'b0;
    end else begin
      if (emit_go) ovalid_r <= 1'b1;
      else if (out_ready) ovalid_r <= 1'b0;
      case (st_r)
        ST_CLR: begin
          clr_r <= clr_r + 1'b1;
          if (clr_r == EW'(NUM_EDGES - 1)) st_r <= ST_IDLE;
        end
        ST_IDLE: begin
          // Edge writes go straight through the memory write port
          if (cmd_valid && cmd_data.is_solve) begin
            if (!tgt_ok) begin
              st_r <= ST_FAIL;
            end else begin
              seen_r      <= NUM_CELLS'(1);
              parent_r[0] <= '0;
              dist_r[0]   <= '0;
              queue_r[0]  <= '0;
              head_r      <= '0;
              tail_r      <= (CW+1)'(1);
              st_r        <= ST_POP;
            end
          end
        end
        ST_POP: begin
          if (head_r >= tail_r) begin
            st_r <= seen_r[target] ? ST_BACK : ST_FAIL;
            cur_r <= target;
            i_r   <= dist_r[target];
            len_r <= dist_r[target];
          end else begin
            cur_r  <= qc;
            head_r <= head_r + 1'b1;
            s_r    <= SIDE_N;
            if (qc == target) begin
              st_r  <= ST_BACK;
              cur_r <= target;
              i_r   <= dist_r[target];
              len_r <= dist_r[target];
            end else begin
              st_r <= ST_NBR;
            end
          end
        end
        ST_NBR: begin
          if (nbr_ok && !seen_r[nbr] && int'(tail_r) < NUM_CELLS) begin
            seen_r[nbr]   <= 1'b1;
            parent_r[nbr] <= cur_r;
            dist_r[nbr]   <= dist_r[cur_r] + 1'b1;
            queue_r[tail_r[CW-1:0]] <= nbr;
            tail_r <= tail_r + 1'b1;
          end
          s_r <= s_r + 1'b1;
          if (s_r == SIDE_W) st_r <= ST_POP;
        end
        ST_BACK: begin
          stack_r[i_r] <= cur_r;
          cur_r <= parent_r[cur_r];
          if (i_r == '0) begin
            st_r      <= ST_EMIT;
            heading_r <= SIDE_N;
          end else begin
            i_r <= i_r - 1'b1;
          end
        end
        ST_EMIT: begin
          if (slot) begin
            odata_r.path_x <= ex;
            odata_r.path_y <= ey;
            odata_r.step   <= i_r;
            odata_r.turn   <= (i_r == '0) ? 2'd0 : move - heading_r;
            odata_r.found  <= 1'b1;
            odata_r.last   <= (i_r == len_r);
            if (i_r != '0) heading_r <= move;
            px_r <= ex;
            py_r <= ey;
            i_r  <= i_r + 1'b1;
            if (i_r == len_r) st_r <= ST_IDLE;
          end
        end
        ST_FAIL: begin
          if (slot) begin
            odata_r  <= '{path_x: '0, path_y: '0, step: '0, turn: '0,
                          found: 1'b0, last: 1'b1};
            st_r     <= ST_IDLE;
          end
        end
        default: st_r <= ST_IDLE;
      endcase
    end
  end
endmodule

FILE: hdl/maze_shortest_path_search.sv
// Top level of the grid maze shortest-path search block.
// Depends on msps_pkg, msps_if, msps_cfg_if, msps_front, msps_back.
//
// Channels: in (func, cell_x, cell_y, side, open), out (path_x, path_y,
// step, turn, found, last) and cfg (index 0 target_x, 1 target_y), all
// valid/ready; a transaction happens when valid and ready are both high.
// An edge-write item updates one shared wall/passage bit and gives no
// result; writes outside the grid are dropped. A solve item runs a
// breadth-first search from (0,0), trying north, east, south, west.
// Sequence: the back end pops queued cells until the target comes up or
// the queue is empty, checks the four neighbors of each expanded cell,
// backtracks over the path cells, then emits one result per cycle while
// out_ready is high. The search loop in the back end sets the throughput;
// edge writes are written while the back end is idle. A two-entry queue
// between front and back lets items be taken while the back end is busy.
// Reset: target (3,4), queue and output empty; the back end then clears
// all edge-memory bits (all blocked) before it takes its first command,
// while the front queue still takes up to two items.
// A stalled receiver holds the result register and the emit sequence.
module maze_shortest_path_search import msps_pkg::*; (
  input logic clk,
  input logic rst_n,
  msps_if.sink       in,
  msps_if.source     out,
  msps_cfg_if.sink   cfg
);
  logic [XW-1:0] tgt_x_r;
  logic [YW-1:0] tgt_y_r;
  logic          cmd_valid, cmd_ready;
  cmd_t          cmd_data;

  assign cfg.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tgt_x_r <= XW'(3);
      tgt_y_r <= YW'(4);
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_TARGET_X: tgt_x_r <= cfg.data[XW-1:0];
        REG_TARGET_Y: tgt_y_r <= cfg.data[YW-1:0];
        default: ;
      endcase
    end
  end

  msps_front u_front (
    .clk, .rst_n,
    .in_valid(in.valid), .in_ready(in.ready), .in_data(in.data),
    .cmd_valid, .cmd_ready, .cmd_data
  );

  msps_back u_back (
    .clk, .rst_n,
    .cmd_valid, .cmd_ready, .cmd_data,
    .tgt_x(tgt_x_r), .tgt_y(tgt_y_r),
    .out_valid(out.valid), .out_ready(out.ready), .out_data(out.data)
  );
endmodule
